>>> sv/vas_pkg.sv
// Shared types, codes and helpers of the vertex attribute submission block.
// Used by vas_range, vertex_attribute_submission and the bench; depends on nothing.
package vas_pkg;

  localparam logic [12:0] MethodMask = 13'h1FFC;

  // configuration register indexes
  localparam logic [2:0] CfgInlineArray = 3'd0;
  localparam logic [2:0] CfgData2f      = 3'd1;
  localparam logic [2:0] CfgData4ub     = 3'd2;
  localparam logic [2:0] CfgData4f      = 3'd3;
  localparam logic [2:0] CfgPosition4f  = 3'd4;

  typedef enum logic [2:0] {
    STEP_IGNORED   = 3'd0,
    STEP_STATE     = 3'd1,
    STEP_INLINE    = 3'd2,
    STEP_VERTEX    = 3'd3,
    STEP_OVERFLOW  = 3'd4,
    STEP_BATCH_END = 3'd5
  } step_kind_t;

  typedef enum logic [1:0] {
    BATCH_NONE      = 2'd0,
    BATCH_IMMEDIATE = 2'd1,
    BATCH_INLINE    = 2'd2
  } batch_kind_t;

  // method ranges, in decode priority order
  typedef enum logic [2:0] {
    RG_INLINE,
    RG_DATA2F,
    RG_DATA4UB,
    RG_DATA4F,
    RG_POS4F
  } range_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ACT,
    ST_PRIME,
    ST_EMIT,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] rel;
  } range_res_t;

  typedef struct packed {
    batch_kind_t kind;
    logic [12:0] words;
    logic        ovf;
  } snap_t;

  // immediate batch takes priority over inline
  function automatic snap_t take_snapshot(input logic [12:0] imm_cnt,
                                          input logic        imm_ovf,
                                          input logic [12:0] inl_cnt,
                                          input logic        inl_ovf);
    snap_t s;
    priority if (imm_cnt != 13'd0) begin
      s.kind  = BATCH_IMMEDIATE;
      s.words = imm_cnt;
      s.ovf   = imm_ovf;
    end else if (inl_cnt != 13'd0) begin
      s.kind  = BATCH_INLINE;
      s.words = inl_cnt;
      s.ovf   = inl_ovf;
    end else begin
      s.kind  = BATCH_NONE;
      s.words = 13'd0;
      s.ovf   = 1'b0;
    end
    return s;
  endfunction

endpackage

>>> sv/vas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vas_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/vas_range.sv
// Shared range compare unit: offset of a method from a range base and hit test.
// Depends on vas_pkg.
module vas_range import vas_pkg::*; (
  input  logic [12:0] method,
  input  logic [12:0] base,
  input  logic [8:0]  span,
  output range_res_t  res
);

  logic [13:0] diff;

  // borrow out means method lies below the base
  assign diff    = {1'b0, method} - {1'b0, base};
  assign res.hit = !diff[13] && (diff[12:0] < {4'b0000, span});
  assign res.rel = diff[7:0];

endmodule

>>> sv/vertex_attribute_submission.sv
// Top level of the vertex attribute submission block: sequencer, counters,
// attribute store and result register. Depends on vas_pkg, vas_range, vas_ram.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  item     | item_valid / item_stall  | command, method_address, method_data
//  result   | result_valid/result_stall| step_kind .. batch_overflow
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One item at a time. The five method ranges are tested in turn by one shared
// subtract and compare unit, one range per cycle. A method write offers a
// single result unless it completes a vertex that fits; such a vertex primes
// the store read first, then streams one word per cycle for 4*ATTRIBUTE_SLOTS
// words, paced by the result side. An end of batch offers its result in the
// cycle after it is accepted.
// Reset clears the counters, flags and every store valid bit at once; the
// store itself is never swept. item_stall stays high until the last result
// of the current item has been transferred.
module vertex_attribute_submission import vas_pkg::*; #(
  parameter int ATTRIBUTE_SLOTS = 16,
  parameter int INLINE_DEPTH    = 4096,
  parameter int IMMEDIATE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        command,
  input  logic [12:0] method_address,
  input  logic [31:0] method_data,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  step_kind,
  output logic [12:0] word_offset,
  output logic [6:0]  word_count,
  output logic [31:0] word_data,
  output logic        last,
  output logic [1:0]  batch_kind,
  output logic [12:0] batch_words,
  output logic        batch_overflow,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int Words = ATTRIBUTE_SLOTS * 4;
  localparam int AddrW = $clog2(Words);
  localparam logic [AddrW-1:0] LastIdx   = AddrW'(Words - 1);
  localparam logic [12:0]      WordsW    = 13'(Words);
  localparam logic [6:0]       WordsCnt  = 7'(Words);
  localparam logic [12:0]      InlLimit  = 13'(INLINE_DEPTH);
  localparam logic [12:0]      ImmLimit  = 13'(IMMEDIATE_DEPTH - Words);
  localparam logic [12:0]      ImmMax    = 13'(IMMEDIATE_DEPTH);
  localparam logic [8:0]       Span2f    = 9'(ATTRIBUTE_SLOTS * 8);
  localparam logic [8:0]       Span4ub   = 9'(ATTRIBUTE_SLOTS * 4);
  localparam logic [8:0]       Span4f    = 9'(ATTRIBUTE_SLOTS * 16);

  // configuration registers
  logic [12:0] inline_array_method;
  logic [12:0] data2f_base_method;
  logic [12:0] data4ub_base_method;
  logic [12:0] data4f_base_method;
  logic [12:0] position4f_base_method;

  state_t      state, state_next;
  range_t      rng, rng_next;
  range_t      act_range, act_range_next;
  logic [7:0]  act_rel, act_rel_next;
  logic [12:0] m_reg;
  logic [31:0] data_reg;

  logic [12:0] inline_count, inline_count_next;
  logic        inline_ovf, inline_ovf_next;
  logic [12:0] imm_count, imm_count_next;
  logic        imm_ovf, imm_ovf_next;

  logic [AddrW-1:0] emit_idx, emit_idx_next;
  logic [12:0]      emit_start, emit_start_next;

  // attribute store and its valid bits
  logic [Words-1:0] valid_bits;
  logic             rd_vld;
  logic [31:0]      rd_data;
  logic [AddrW-1:0] rd_addr;
  logic             st_we;
  logic [AddrW-1:0] st_waddr;
  logic [5:0]       widx;
  logic             completes;

  // shared range unit
  logic [12:0] rg_base;
  logic [8:0]  rg_span;
  range_res_t  rres;

  // result register loading
  logic        out_load;
  logic        out_free;
  logic        use_cur_snap;
  step_kind_t  step_kind_next;
  logic [12:0] word_offset_next;
  logic [6:0]  word_count_next;
  logic [31:0] word_data_next;
  logic        last_next;
  snap_t       snap_cur, snap_out;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign snap_cur   = take_snapshot(imm_count, imm_ovf, inline_count, inline_ovf);

  vas_range u_range (
    .method (m_reg),
    .base   (rg_base),
    .span   (rg_span),
    .res    (rres)
  );

  vas_ram #(
    .Width (32),
    .Depth (Words)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (data_reg),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inline_array_method    <= 13'd6168;
      data2f_base_method     <= 13'd6272;
      data4ub_base_method    <= 13'd6464;
      data4f_base_method     <= 13'd6656;
      position4f_base_method <= 13'd5400;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgInlineArray: inline_array_method    <= cfg_data;
        CfgData2f:      data2f_base_method     <= cfg_data;
        CfgData4ub:     data4ub_base_method    <= cfg_data;
        CfgData4f:      data4f_base_method     <= cfg_data;
        CfgPosition4f:  position4f_base_method <= cfg_data;
        default: ;
      endcase
    end
  end

  // pick the range under test
  always_comb begin
    unique case (rng)
      RG_INLINE: begin
        rg_base = inline_array_method;
        rg_span = 9'd1;
      end
      RG_DATA2F: begin
        rg_base = data2f_base_method;
        rg_span = Span2f;
      end
      RG_DATA4UB: begin
        rg_base = data4ub_base_method;
        rg_span = Span4ub;
      end
      RG_DATA4F: begin
        rg_base = data4f_base_method;
        rg_span = Span4f;
      end
      default: begin
        rg_base = position4f_base_method;
        rg_span = 9'd16;
      end
    endcase
  end

  // store slot from the offset within the hit range, and the completing write
  always_comb begin
    unique case (act_range)
      RG_DATA2F: begin
        widx      = {act_rel[6:3], 1'b0, act_rel[2]};
        completes = (act_rel[6:2] == 5'd1);
      end
      RG_DATA4UB: begin
        widx      = {act_rel[5:2], 2'b00};
        completes = (act_rel[5:2] == 4'd0);
      end
      RG_DATA4F: begin
        widx      = act_rel[7:2];
        completes = (act_rel[7:2] == 6'd3);
      end
      RG_POS4F: begin
        widx      = {4'b0000, act_rel[3:2]};
        completes = (act_rel[3:2] == 2'd3);
      end
      default: begin
        widx      = 6'd0;
        completes = 1'b0;
      end
    endcase
  end

  assign st_waddr = widx[AddrW-1:0];

  // sequencer
  always_comb begin
    state_next        = state;
    rng_next          = rng;
    act_range_next    = act_range;
    act_rel_next      = act_rel;
    inline_count_next = inline_count;
    inline_ovf_next   = inline_ovf;
    imm_count_next    = imm_count;
    imm_ovf_next      = imm_ovf;
    emit_idx_next     = emit_idx;
    emit_start_next   = emit_start;
    rd_addr           = emit_idx;
    st_we             = 1'b0;
    out_load          = 1'b0;
    use_cur_snap      = 1'b0;
    step_kind_next    = STEP_IGNORED;
    word_offset_next  = 13'd0;
    word_count_next   = 7'd0;
    word_data_next    = 32'd0;
    last_next         = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (command) begin
            // report the batch as it stands, then clear counts and flags
            out_load          = 1'b1;
            use_cur_snap      = 1'b1;
            step_kind_next    = STEP_BATCH_END;
            inline_count_next = 13'd0;
            inline_ovf_next   = 1'b0;
            imm_count_next    = 13'd0;
            imm_ovf_next      = 1'b0;
            state_next        = ST_WAIT;
          end else begin
            rng_next   = RG_INLINE;
            state_next = ST_DECODE;
          end
        end
      end

      ST_DECODE: begin
        if (rres.hit) begin
          act_range_next = rng;
          act_rel_next   = rres.rel;
          state_next     = ST_ACT;
        end else if (rng == RG_POS4F) begin
          out_load       = 1'b1;
          step_kind_next = STEP_IGNORED;
          state_next     = ST_WAIT;
        end else begin
          unique case (rng)
            RG_INLINE:  rng_next = RG_DATA2F;
            RG_DATA2F:  rng_next = RG_DATA4UB;
            RG_DATA4UB: rng_next = RG_DATA4F;
            default:    rng_next = RG_POS4F;
          endcase
        end
      end

      ST_ACT: begin
        emit_idx_next = '0;
        state_next    = ST_WAIT;
        if (act_range == RG_INLINE) begin
          out_load = 1'b1;
          if (inline_count >= InlLimit) begin
            inline_ovf_next  = 1'b1;
            step_kind_next   = STEP_OVERFLOW;
            word_offset_next = inline_count;
          end else begin
            inline_count_next = inline_count + 13'd1;
            step_kind_next    = STEP_INLINE;
            word_offset_next  = inline_count;
            word_count_next   = 7'd1;
            word_data_next    = data_reg;
          end
        end else begin
          st_we = 1'b1;
          if (!completes) begin
            out_load       = 1'b1;
            step_kind_next = STEP_STATE;
          end else if (imm_count > ImmLimit) begin
            out_load         = 1'b1;
            imm_ovf_next     = 1'b1;
            step_kind_next   = STEP_OVERFLOW;
            word_offset_next = imm_count;
          end else begin
            emit_start_next = imm_count;
            imm_count_next  = imm_count + WordsW;
            state_next      = ST_PRIME;
          end
        end
      end

      ST_PRIME: begin
        // first store word lands in the read register
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load         = 1'b1;
          step_kind_next   = STEP_VERTEX;
          word_offset_next = emit_start;
          word_count_next  = WordsCnt;
          word_data_next   = rd_vld ? rd_data : 32'd0;
          last_next        = (emit_idx == LastIdx);
          if (emit_idx == LastIdx) begin
            state_next = ST_WAIT;
          end else begin
            emit_idx_next = emit_idx + AddrW'(1);
            rd_addr       = emit_idx + AddrW'(1);
          end
        end
      end

      default: begin
        // ST_WAIT: hold until the final result has gone
        if (result_valid && !result_stall) begin
          state_next = ST_IDLE;
        end
      end
    endcase

    snap_out = use_cur_snap ? snap_cur
             : take_snapshot(imm_count_next, imm_ovf_next,
                             inline_count_next, inline_ovf_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rng          <= RG_INLINE;
      inline_count <= 13'd0;
      inline_ovf   <= 1'b0;
      imm_count    <= 13'd0;
      imm_ovf      <= 1'b0;
      valid_bits   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      rng          <= rng_next;
      inline_count <= inline_count_next;
      inline_ovf   <= inline_ovf_next;
      imm_count    <= imm_count_next;
      imm_ovf      <= imm_ovf_next;
      if (st_we) begin
        valid_bits[st_waddr] <= 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_range  <= act_range_next;
    act_rel    <= act_rel_next;
    emit_idx   <= emit_idx_next;
    emit_start <= emit_start_next;
    rd_vld     <= valid_bits[rd_addr];
    if (item_valid && !item_stall) begin
      m_reg    <= method_address & MethodMask;
      data_reg <= method_data;
    end
    if (out_load) begin
      step_kind      <= step_kind_next;
      word_offset    <= word_offset_next;
      word_count     <= word_count_next;
      word_data      <= word_data_next;
      last           <= last_next;
      batch_kind     <= snap_out.kind;
      batch_words    <= snap_out.words;
      batch_overflow <= snap_out.ovf;
    end
  end

`ifndef SYNTHESIS
  a_inline_bound: assert property (@(posedge clk) disable iff (rst)
    inline_count <= InlLimit)
    else $error("inline count beyond buffer depth");

  a_imm_bound: assert property (@(posedge clk) disable iff (rst)
    imm_count <= ImmMax)
    else $error("immediate count beyond buffer depth");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("second item taken while one is in progress");

  a_vertex_batch: assert property (@(posedge clk) disable iff (rst)
    (result_valid && step_kind == STEP_VERTEX) |->
      (batch_kind == BATCH_IMMEDIATE && batch_words != 13'd0))
    else $error("vertex word without an immediate batch snapshot");
`endif

endmodule

>>> bench/tb_vertex_attribute_submission.sv
// Self-checking bench for vertex_attribute_submission: an own model of the
// store, batch counters and method registers predicts every result transfer.
// Depends on vas_pkg and the block's RTL; reads and writes no files.
module tb_vertex_attribute_submission;
  timeunit 1ns;
  timeprecision 1ps;

  import vas_pkg::*;

  localparam int ClkPeriod    = 20;
  localparam int ResetCycles  = 11;
  localparam int Slots        = 16;
  localparam int InlineDepth  = 4096;
  localparam int ImmDepth     = 4096;
  localparam int VertexWords  = Slots * 4;
  localparam int MaxReports   = 10;
  localparam int HoldoffLen   = 300;
  localparam int DrainCycles  = 16;
  localparam int CycleLimit   = 1_000_000;

  // method register values after reset
  localparam logic [12:0] DefInline     = 13'd6168;
  localparam logic [12:0] DefData2f     = 13'd6272;
  localparam logic [12:0] DefData4ub    = 13'd6464;
  localparam logic [12:0] DefData4f     = 13'd6656;
  localparam logic [12:0] DefPosition4f = 13'd5400;

  // one result transfer, as seen on the result channel
  typedef struct packed {
    step_kind_t  kind;
    logic [12:0] offset;
    logic [6:0]  count;
    logic [31:0] data;
    logic        last;
    batch_kind_t bkind;
    logic [12:0] bwords;
    logic        bovf;
  } step_result_t;

  // Mirrors the block's state, turns each accepted item into the result
  // transfers it must produce and compares those as they come out.
  class vertex_scoreboard;
    logic [12:0]  method_reg [5];
    logic [31:0]  attr_words [VertexWords];
    int unsigned  inline_count, immediate_count;
    bit           inline_ovf, immediate_ovf;
    step_result_t awaited [$];
    int unsigned  items, checked, failures, vertices, overflows, batch_ends, settings;

    function new();
      method_reg[CfgInlineArray] = DefInline;
      method_reg[CfgData2f]      = DefData2f;
      method_reg[CfgData4ub]     = DefData4ub;
      method_reg[CfgData4f]      = DefData4f;
      method_reg[CfgPosition4f]  = DefPosition4f;
      foreach (attr_words[i]) attr_words[i] = '0;
      settings = 1;
    endfunction

    function void set_register(logic [2:0] idx, logic [12:0] value);
      method_reg[idx] = value;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // immediate batch wins over inline when both hold words
    function step_result_t batch_view();
      step_result_t r;
      r = '0;
      if (immediate_count != 0) begin
        r.bkind  = BATCH_IMMEDIATE;
        r.bwords = 13'(immediate_count);
        r.bovf   = immediate_ovf;
      end else if (inline_count != 0) begin
        r.bkind  = BATCH_INLINE;
        r.bwords = 13'(inline_count);
        r.bovf   = inline_ovf;
      end else begin
        r.bkind  = BATCH_NONE;
      end
      return r;
    endfunction

    function void push_one(step_kind_t kind, int unsigned off, int unsigned cnt,
                           logic [31:0] data);
      step_result_t r;
      r        = batch_view();
      r.kind   = kind;
      r.offset = 13'(off);
      r.count  = 7'(cnt);
      r.data   = data;
      r.last   = 1'b1;
      awaited.push_back(r);
    endfunction

    function void put_word(int unsigned attr, int unsigned comp, logic [31:0] data);
      attr_words[((attr % Slots) * 4 + (comp % 4)) % VertexWords] = data;
    endfunction

    // append a whole vertex to the immediate buffer, or flag it as lost
    function void finish_vertex();
      step_result_t r;
      int unsigned  start;
      if (immediate_count > ImmDepth - VertexWords) begin
        immediate_ovf = 1'b1;
        overflows++;
        push_one(STEP_OVERFLOW, immediate_count, 0, '0);
        return;
      end
      start = immediate_count;
      immediate_count += VertexWords;
      vertices++;
      r        = batch_view();
      r.kind   = STEP_VERTEX;
      r.offset = 13'(start);
      r.count  = 7'(VertexWords);
      for (int i = 0; i < VertexWords; i++) begin
        r.data = attr_words[i];
        r.last = (i == VertexWords - 1);
        awaited.push_back(r);
      end
    endfunction

    function void note_item(bit cmd, logic [12:0] addr, logic [31:0] data);
      int unsigned m, base, rel, attr, comp;
      items++;
      m = 32'(addr & MethodMask);
      if (cmd) begin
        push_one(STEP_BATCH_END, 0, 0, '0);
        batch_ends++;
        inline_count    = 0;
        inline_ovf      = 1'b0;
        immediate_count = 0;
        immediate_ovf   = 1'b0;
        return;
      end
      if (m == method_reg[CfgInlineArray]) begin
        if (inline_count >= InlineDepth) begin
          inline_ovf = 1'b1;
          overflows++;
          push_one(STEP_OVERFLOW, inline_count, 0, '0);
        end else begin
          rel = inline_count;
          inline_count++;
          push_one(STEP_INLINE, rel, 1, data);
        end
        return;
      end
      base = method_reg[CfgData2f];
      if (m >= base && m < base + Slots * 8) begin
        rel  = m - base;
        attr = rel / 8;
        comp = (rel % 8) / 4;
        put_word(attr, comp, data);
        if (attr == 0 && comp == 1) finish_vertex();
        else push_one(STEP_STATE, 0, 0, '0);
        return;
      end
      base = method_reg[CfgData4ub];
      if (m >= base && m < base + Slots * 4) begin
        attr = (m - base) / 4;
        put_word(attr, 0, data);
        if (attr == 0) finish_vertex();
        else push_one(STEP_STATE, 0, 0, '0);
        return;
      end
      base = method_reg[CfgData4f];
      if (m >= base && m < base + Slots * 16) begin
        rel  = m - base;
        attr = rel / 16;
        comp = (rel % 16) / 4;
        put_word(attr, comp, data);
        if (attr == 0 && comp == 3) finish_vertex();
        else push_one(STEP_STATE, 0, 0, '0);
        return;
      end
      base = method_reg[CfgPosition4f];
      if (m >= base && m < base + 16) begin
        comp = (m - base) / 4;
        put_word(0, comp, data);
        if (comp == 3) finish_vertex();
        else push_one(STEP_STATE, 0, 0, '0);
        return;
      end
      push_one(STEP_IGNORED, 0, 0, '0);
    endfunction

    function string describe(step_result_t r);
      return $sformatf("kind=%0d off=%0d cnt=%0d data=%08h last=%0b batch=%0d/%0d ovf=%0b",
                       r.kind, r.offset, r.count, r.data, r.last, r.bkind, r.bwords,
                       r.bovf);
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("ERROR: result with nothing outstanding: %s", describe(got));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.offset !== want.offset ||
          got.count !== want.count || got.data !== want.data ||
          got.last !== want.last || got.bkind !== want.bkind ||
          got.bwords !== want.bwords || got.bovf !== want.bovf) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("ERROR: result %0d differs", checked);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the signals of the three channels. Every input starts
  // from a known value so the block never sees X before reset takes hold.
  // ---------------------------------------------------------------------------
  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        item_valid     = 1'b0;
  logic        item_stall;
  logic        command        = 1'b0;
  logic [12:0] method_address = '0;
  logic [31:0] method_data    = '0;
  logic        result_valid;
  logic        result_stall   = 1'b0;
  logic [2:0]  step_kind;
  logic [12:0] word_offset;
  logic [6:0]  word_count;
  logic [31:0] word_data;
  logic        last;
  logic [1:0]  batch_kind;
  logic [12:0] batch_words;
  logic        batch_overflow;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index      = '0;
  logic [12:0] cfg_data       = '0;

  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  bit          results_held   = 1'b0;
  int unsigned cycle_count    = 0;
  event        start_holdoff;

  vertex_scoreboard sb;

  always #(ClkPeriod / 2) clk = ~clk;

  vertex_attribute_submission u_top (.*);

  // Receiver: stall at the current idling rate, and solidly while a hold-off
  // is running so that the block backs up into its item channel.
  always @(posedge clk) begin
    result_stall <= results_held || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Hold-off: count its own cycles, independent of what the sender is doing.
  always begin : result_holdoff
    @(start_holdoff);
    for (int n = 0; n < HoldoffLen; n++) begin
      results_held <= 1'b1;
      @(posedge clk);
    end
    results_held <= 1'b0;
  end

  // Check every result transfer against the oldest outstanding prediction.
  always @(posedge clk) begin : result_monitor
    step_result_t seen;
    if (!rst && result_valid && !result_stall) begin
      seen.kind   = step_kind_t'(step_kind);
      seen.offset = word_offset;
      seen.count  = word_count;
      seen.data   = word_data;
      seen.last   = last;
      seen.bkind  = batch_kind_t'(batch_kind);
      seen.bwords = batch_words;
      seen.bovf   = batch_overflow;
      sb.check_result(seen);
    end
  end

  // Watchdog: give up well beyond the slowest legitimate run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("ERROR: no progress after %0d cycles, %0d results outstanding",
               cycle_count, sb.outstanding());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------

  task automatic set_idling(input int sender, input int receiver);
    send_idle_pct <= sender;
    recv_idle_pct <= receiver;
  endtask

  // Offer one item, idling first at the sender's rate, and note it at the
  // edge where the transfer happens. Valid stays high into the next item
  // unless the sender decides to idle.
  task automatic send_item(input bit cmd, input logic [12:0] addr,
                           input logic [31:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid     <= 1'b1;
    command        <= cmd;
    method_address <= addr;
    method_data    <= data;
    do @(posedge clk); while (item_stall);
    sb.note_item(cmd, addr, data);
  endtask

  // Drop valid and wait until every predicted result has been transferred.
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Write all five method registers back to back; valid stays high between
  // transfers and drops after the last one.
  task automatic load_registers(input logic [12:0] inl, input logic [12:0] d2f,
                                input logic [12:0] d4ub, input logic [12:0] d4f,
                                input logic [12:0] pos);
    logic [2:0]  order [5];
    logic [12:0] value [5];
    order = '{CfgInlineArray, CfgData2f, CfgData4ub, CfgData4f, CfgPosition4f};
    value = '{inl, d2f, d4ub, d4f, pos};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= value[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_register(order[i], value[i]);
    end
    cfg_valid <= 1'b0;
    sb.settings++;
  endtask

  // Inline append address with the ignored low bits scrambled.
  function automatic logic [12:0] inline_address();
    logic [12:0] a;
    a      = sb.method_reg[CfgInlineArray];
    a[1:0] = 2'($urandom_range(0, 3));
    return a;
  endfunction

  // Attribute write aimed at one of the four ranges; when completing, aim at
  // the component that finishes a vertex in that range.
  function automatic logic [12:0] attribute_address(input bit completing);
    logic [12:0] a;
    int unsigned pick, attr, comp;
    pick = $urandom_range(0, 3);
    attr = completing ? 0 : $urandom_range(0, Slots - 1);
    case (pick)
      0: begin
        comp = completing ? 1 : $urandom_range(0, 1);
        a = 13'(sb.method_reg[CfgData2f] + attr * 8 + comp * 4);
      end
      1: begin
        a = 13'(sb.method_reg[CfgData4ub] + attr * 4);
      end
      2: begin
        comp = completing ? 3 : $urandom_range(0, 3);
        a = 13'(sb.method_reg[CfgData4f] + attr * 16 + comp * 4);
      end
      default: begin
        comp = completing ? 3 : $urandom_range(0, 3);
        a = 13'(sb.method_reg[CfgPosition4f] + comp * 4);
      end
    endcase
    a[1:0] = 2'($urandom_range(0, 3));
    return a;
  endfunction

  // Random traffic, mostly well-formed: runs of attribute writes closed by a
  // completing write, runs of inline words, occasional batch ends, and some
  // noise at arbitrary addresses (not counted towards the total).
  task automatic drive_random(input int count);
    int sent, pick, n;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = $urandom_range(0, 5);
        repeat (n) begin
          send_item(1'b0, attribute_address(1'b0), $urandom);
          sent++;
        end
        send_item(1'b0, attribute_address(1'b1), $urandom);
        sent++;
      end else if (pick < 80) begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          send_item(1'b0, inline_address(), $urandom);
          sent++;
        end
      end else if (pick < 88) begin
        send_item(1'b1, 13'($urandom), $urandom);
        sent++;
      end else begin
        send_item(1'b0, 13'($urandom), $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Reset settings; sender idles a third of the time, receiver over half.
    set_idling(33, 57);
    @(posedge clk);

    // Directed: empty batch end, unknown methods at both ends of the address
    // space, inline words, every range's far attribute and its completing
    // write, addresses just past the two-float and position ranges, and a batch end that clears.
    send_item(1'b1, 13'h1FFF, 32'hFFFF_FFFF);
    send_item(1'b0, 13'h0000, 32'hFFFF_FFFF);
    send_item(1'b0, 13'h1FFF, 32'h0000_0000);
    send_item(1'b0, DefInline | 13'd3, 32'hFFFF_FFFF);
    send_item(1'b0, DefInline, 32'h0000_0000);
    send_item(1'b0, DefData2f + 13'd124, 32'hA5A5_5A5A);
    send_item(1'b0, DefData2f, 32'h1111_0000);
    send_item(1'b0, DefData2f + 13'd4, 32'h1111_0001);
    send_item(1'b0, DefData4ub + 13'd60, 32'h8000_0001);
    send_item(1'b0, DefData4ub, 32'h0102_0304);
    send_item(1'b0, DefData4f + 13'd252, 32'h7FFF_FFFF);
    send_item(1'b0, DefData4f, 32'h3F80_0000);
    send_item(1'b0, DefData4f + 13'd12, 32'h4000_0000);
    send_item(1'b0, DefPosition4f, 32'hC0DE_0000);
    send_item(1'b0, DefPosition4f + 13'd4, 32'hC0DE_0001);
    send_item(1'b0, DefPosition4f + 13'd9, 32'hC0DE_0002);
    send_item(1'b0, DefPosition4f + 13'd15, 32'hC0DE_0003);
    send_item(1'b0, DefData2f + 13'd128, 32'hDEAD_BEEF);
    send_item(1'b0, DefPosition4f + 13'd16, 32'hDEAD_BEEF);
    send_item(1'b1, 13'h0000, 32'h0000_0000);
    send_item(1'b0, DefInline, 32'h5555_AAAA);

    // Random with a long hold-off part way through: the sender keeps
    // offering while results back up.
    drive_random(30);
    -> start_holdoff;
    drive_random(35);
    settle();

    // Extremes and overlapping ranges: inline at zero shadows the four-float
    // base, the four-byte range sits inside the four-float range, and the
    // two-float range starts at the top address. Swap the idling rates.
    load_registers(13'd0, 13'd8188, 13'd4, 13'd0, 13'd4096);
    set_idling(57, 33);
    drive_random(35);
    settle();

    // Random aligned bases, with the two-float base left unaligned.
    load_registers(13'($urandom_range(0, 2047) * 4), 13'($urandom_range(0, 8188)),
                   13'($urandom_range(0, 2047) * 4), 13'($urandom_range(0, 2047) * 4),
                   13'($urandom_range(0, 2047) * 4));
    drive_random(30);
    settle();

    // Back to reset values with no idling on either side.
    load_registers(DefInline, DefData2f, DefData4ub, DefData4f, DefPosition4f);
    set_idling(0, 0);
    drive_random(30);

    // Fill the immediate buffer to the brim and past it: vertices until two
    // are refused, then an inline word while the immediate batch still takes
    // priority in the snapshot.
    send_item(1'b1, 13'h0000, 32'h0000_0000);
    repeat (ImmDepth / VertexWords + 2)
      send_item(1'b0, DefPosition4f + 13'd12, $urandom);
    send_item(1'b0, inline_address(), $urandom);
    send_item(1'b1, 13'h0000, 32'h0000_0000);
    settle();

    // Let any stray result surface before the verdict.
    repeat (DrainCycles) @(posedge clk);
    if (sb.outstanding() != 0) begin
      sb.failures++;
      $display("ERROR: %0d predicted results never arrived", sb.outstanding());
    end

    $display("Covered %0d items over %0d method register settings, %0d results checked;",
             sb.items, sb.settings, sb.checked);
    $display("%0d vertices streamed, %0d overflows, %0d batch ends, %0d mismatches.",
             sb.vertices, sb.overflows, sb.batch_ends, sb.failures);
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> vertex_attribute_submission.f
sv/vas_pkg.sv
sv/vas_ram.sv
sv/vas_range.sv
sv/vertex_attribute_submission.sv
bench/tb_vertex_attribute_submission.sv
